[sv/rsfc_pkg.sv]
// ----------------------------------------------------------------------------
// rsfc_pkg
// Shared types and codes of the RS485 half-duplex frame controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfc_pkg;

  localparam int TX_DEPTH_DEF = 256;
  localparam int RX_DEPTH_DEF = 256;

  localparam logic [15:0] GAP_TICKS_RST  = 16'd35;
  localparam logic [15:0] TURN_TICKS_RST = 16'd35;
  localparam logic [8:0]  CAPACITY_RST   = 9'd256;

  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_RX_BYTE  = 3'd1;
  localparam logic [2:0] ACT_TX_EMPTY = 3'd2;
  localparam logic [2:0] ACT_TX_DONE  = 3'd3;
  localparam logic [2:0] ACT_LINE_ERR = 3'd4;
  localparam logic [2:0] ACT_LOAD     = 3'd5;
  localparam logic [2:0] ACT_READ     = 3'd6;

  localparam logic [1:0] CFG_RX_GAP     = 2'd0;
  localparam logic [1:0] CFG_TURNAROUND = 2'd1;
  localparam logic [1:0] CFG_CAPACITY   = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        drive_enable;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        read_last;
    logic        frame_ready;
    logic [8:0]  frame_length;
    logic [15:0] error_count;
    logic [1:0]  tx_phase;
  } result_t;

endpackage

`default_nettype wire

[sv/rsfc_ram.sv]
// ----------------------------------------------------------------------------
// rsfc_ram
// Byte buffer with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfc_ram #(
  parameter int DEPTH = rsfc_pkg::TX_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/rs485_half_duplex_frame_controller_top.sv]
// ----------------------------------------------------------------------------
// rs485_half_duplex_frame_controller_top
// Event-driven RS485 half-duplex frame controller with idle-gap framing.
// ----------------------------------------------------------------------------
// One event enters per clock. Each event is captured in an input register,
// processed in a single pass that updates the controller state and issues at
// most one write and one read to each byte buffer, and its result is presented
// from the result register, together with the registered buffer read. A
// stalled result holds the pipeline; otherwise the sustained rate is one event
// per cycle. The buffers need no clearing pass after reset.
`default_nettype none

module rs485_half_duplex_frame_controller_top #(
  parameter int TX_DEPTH = rsfc_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = rsfc_pkg::RX_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire rsfc_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output rsfc_pkg::result_t     result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);

  localparam int TAW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RAW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TCW  = $clog2(TX_DEPTH + 1);
  localparam int RCW  = $clog2(RX_DEPTH + 1);
  localparam int CMPW = (RCW > 9) ? RCW : 9;

  typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_SEND = 2'd1, PH_TURN = 2'd2} phase_t;

  // configuration
  logic [15:0] gap_ticks;
  logic [15:0] turn_ticks;
  logic [8:0]  capacity;

  // controller state
  phase_t          phase, phase_next;
  logic [TCW-1:0]  tx_fill, tx_fill_next;
  logic [TCW-1:0]  tx_total, tx_total_next;
  logic [TCW-1:0]  tx_pos, tx_pos_next;
  logic            empty_on, empty_on_next;
  logic            complete_armed, complete_armed_next;
  logic            drive, drive_next;
  logic [RCW-1:0]  rx_count, rx_count_next;
  logic [RCW-1:0]  rx_read_pos, rx_read_pos_next;
  logic            rx_open, rx_open_next;
  logic            rx_done, rx_done_next;
  logic [15:0]     gap_counter, gap_counter_next;
  logic            gap_running, gap_running_next;
  logic [15:0]     err_counter, err_counter_next;

  // input stage
  logic            a_valid;
  rsfc_pkg::item_t a_item;

  // result stage
  logic        b_valid;
  logic        b_accepted, b_tx_valid, b_tx_from_mem, b_read_valid, b_read_from_mem;
  logic        b_read_last, b_drive, b_frame_ready;
  logic [7:0]  b_tx_direct;
  logic [8:0]  b_frame_length;
  logic [15:0] b_error_count;
  logic [1:0]  b_phase;

  logic        accepted_next, tx_valid_next, tx_from_mem_next, read_valid_next;
  logic        read_from_mem_next, read_last_next;

  // buffer ports
  logic           tx_we, rx_we;
  logic [TAW-1:0] tx_waddr, tx_raddr;
  logic [RAW-1:0] rx_waddr, rx_raddr;
  logic [7:0]     rx_wdata;
  logic [7:0]     tx_rdata, rx_rdata;

  logic advance;
  logic rx_full;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] len_ext;

  assign advance    = a_valid && (!b_valid || result_ready);
  assign item_ready = !a_valid || advance;
  assign cfg_ready  = 1'b1;

  assign count_ext = CMPW'(rx_count);
  assign rx_full   = (count_ext >= CMPW'(capacity)) || (rx_count >= RCW'(RX_DEPTH));

  always_comb begin
    phase_next          = phase;
    tx_fill_next        = tx_fill;
    tx_total_next       = tx_total;
    tx_pos_next         = tx_pos;
    empty_on_next       = empty_on;
    complete_armed_next = complete_armed;
    drive_next          = drive;
    rx_count_next       = rx_count;
    rx_read_pos_next    = rx_read_pos;
    rx_open_next        = rx_open;
    rx_done_next        = rx_done;
    gap_counter_next    = gap_counter;
    gap_running_next    = gap_running;
    err_counter_next    = err_counter;
    accepted_next       = 1'b0;
    tx_valid_next       = 1'b0;
    tx_from_mem_next    = 1'b0;
    read_valid_next     = 1'b0;
    read_from_mem_next  = 1'b0;
    read_last_next      = 1'b0;
    tx_we               = 1'b0;
    tx_waddr            = tx_fill[TAW-1:0];
    tx_raddr            = tx_pos[TAW-1:0];
    rx_we               = 1'b0;
    rx_waddr            = rx_count[RAW-1:0];
    rx_wdata            = a_item.data;
    rx_raddr            = rx_read_pos[RAW-1:0];

    case (a_item.action)
      rsfc_pkg::ACT_TICK: begin
        if (gap_running) begin
          if (gap_counter <= 16'd1) begin
            gap_counter_next = '0;
            gap_running_next = 1'b0;
            if (phase == PH_TURN) begin
              phase_next = PH_IDLE;
            end
            if (rx_open) begin
              rx_open_next = 1'b0;
              rx_done_next = 1'b1;
            end
          end else begin
            gap_counter_next = gap_counter - 16'd1;
          end
        end
      end
      rsfc_pkg::ACT_RX_BYTE: begin
        if (rx_done) begin
          err_counter_next = err_counter + 16'd1;
        end else if (rx_open) begin
          gap_counter_next = gap_ticks;
          if (rx_full) begin
            rx_done_next     = 1'b1;
            rx_open_next     = 1'b0;
            err_counter_next = err_counter + 16'd1;
          end else begin
            rx_we         = 1'b1;
            rx_count_next = rx_count + RCW'(1);
          end
        end else begin
          rx_we            = 1'b1;
          rx_waddr         = '0;
          rx_count_next    = RCW'(1);
          rx_read_pos_next = '0;
          gap_counter_next = gap_ticks;
          gap_running_next = 1'b1;
          rx_open_next     = 1'b1;
        end
      end
      rsfc_pkg::ACT_TX_EMPTY: begin
        if (empty_on) begin
          if (phase != PH_SEND) begin
            empty_on_next = 1'b0;
          end else if (tx_pos < tx_total) begin
            tx_valid_next    = 1'b1;
            tx_from_mem_next = 1'b1;
            tx_pos_next      = tx_pos + TCW'(1);
          end else begin
            empty_on_next       = 1'b0;
            complete_armed_next = 1'b1;
          end
        end
      end
      rsfc_pkg::ACT_TX_DONE: begin
        if (complete_armed) begin
          complete_armed_next = 1'b0;
          if (phase == PH_SEND) begin
            drive_next       = 1'b0;
            gap_counter_next = turn_ticks;
            gap_running_next = 1'b1;
            phase_next       = PH_TURN;
          end
        end
      end
      rsfc_pkg::ACT_LINE_ERR: begin
        err_counter_next = err_counter + 16'd1;
      end
      rsfc_pkg::ACT_LOAD: begin
        if (phase == PH_IDLE) begin
          if (tx_fill >= TCW'(TX_DEPTH)) begin
            tx_fill_next = '0;
          end else begin
            accepted_next = 1'b1;
            tx_we         = 1'b1;
            tx_fill_next  = tx_fill + TCW'(1);
            if (a_item.last) begin
              if (rx_open) begin
                rx_open_next     = 1'b0;
                gap_running_next = 1'b0;
              end
              phase_next       = PH_SEND;
              tx_total_next    = tx_fill + TCW'(1);
              tx_fill_next     = '0;
              drive_next       = 1'b1;
              tx_valid_next    = 1'b1;
              tx_from_mem_next = (tx_fill != '0);
              tx_raddr         = '0;
              tx_pos_next      = TCW'(1);
              empty_on_next    = 1'b1;
            end
          end
        end
      end
      rsfc_pkg::ACT_READ: begin
        if (rx_done) begin
          accepted_next      = 1'b1;
          read_valid_next    = 1'b1;
          read_from_mem_next = (rx_read_pos < rx_count);
          rx_read_pos_next   = rx_read_pos + RCW'(1);
          if (rx_read_pos + RCW'(1) >= rx_count) begin
            read_last_next = 1'b1;
            rx_done_next   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign len_ext = CMPW'(rx_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks      <= rsfc_pkg::GAP_TICKS_RST;
      turn_ticks     <= rsfc_pkg::TURN_TICKS_RST;
      capacity       <= rsfc_pkg::CAPACITY_RST;
      phase          <= PH_IDLE;
      tx_fill        <= '0;
      tx_total       <= '0;
      tx_pos         <= '0;
      empty_on       <= 1'b0;
      complete_armed <= 1'b0;
      drive          <= 1'b0;
      rx_count       <= '0;
      rx_read_pos    <= '0;
      rx_open        <= 1'b0;
      rx_done        <= 1'b0;
      gap_counter    <= '0;
      gap_running    <= 1'b0;
      err_counter    <= '0;
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rsfc_pkg::CFG_RX_GAP:     gap_ticks  <= cfg_data;
          rsfc_pkg::CFG_TURNAROUND: turn_ticks <= cfg_data;
          rsfc_pkg::CFG_CAPACITY:   capacity   <= cfg_data[8:0];
          default: begin
          end
        endcase
      end
      if (item_ready) begin
        a_valid <= item_valid;
      end
      if (advance) begin
        phase          <= phase_next;
        tx_fill        <= tx_fill_next;
        tx_total       <= tx_total_next;
        tx_pos         <= tx_pos_next;
        empty_on       <= empty_on_next;
        complete_armed <= complete_armed_next;
        drive          <= drive_next;
        rx_count       <= rx_count_next;
        rx_read_pos    <= rx_read_pos_next;
        rx_open        <= rx_open_next;
        rx_done        <= rx_done_next;
        gap_counter    <= gap_counter_next;
        gap_running    <= gap_running_next;
        err_counter    <= err_counter_next;
        b_valid        <= 1'b1;
      end else if (result_ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_ready) begin
      a_item <= item;
    end
    if (advance) begin
      b_accepted      <= accepted_next;
      b_tx_valid      <= tx_valid_next;
      b_tx_from_mem   <= tx_from_mem_next;
      b_tx_direct     <= a_item.data;
      b_drive         <= drive_next;
      b_read_valid    <= read_valid_next;
      b_read_from_mem <= read_from_mem_next;
      b_read_last     <= read_last_next;
      b_frame_ready   <= rx_done_next;
      b_frame_length  <= len_ext[8:0];
      b_error_count   <= err_counter_next;
      b_phase         <= phase_next;
    end
  end

  rsfc_ram #(.DEPTH(TX_DEPTH), .AW(TAW)) u_tx_ram (
    .clk   (clk),
    .we    (advance && tx_we),
    .waddr (tx_waddr),
    .wdata (a_item.data),
    .re    (advance),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  rsfc_ram #(.DEPTH(RX_DEPTH), .AW(RAW)) u_rx_ram (
    .clk   (clk),
    .we    (advance && rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .re    (advance),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  assign result_valid = b_valid;

  always_comb begin
    result              = '0;
    result.accepted     = b_accepted;
    result.tx_valid     = b_tx_valid;
    result.tx_byte      = b_tx_valid ? (b_tx_from_mem ? tx_rdata : b_tx_direct) : 8'd0;
    result.drive_enable = b_drive;
    result.read_valid   = b_read_valid;
    result.read_byte    = (b_read_valid && b_read_from_mem) ? rx_rdata : 8'd0;
    result.read_last    = b_read_last;
    result.frame_ready  = b_frame_ready;
    result.frame_length = b_frame_length;
    result.error_count  = b_error_count;
    result.tx_phase     = b_phase;
  end

endmodule

`default_nettype wire
